>>> rtl/qpr_pkg.sv
// Shared types and constants for the quaternion point rotator.
// Used by every module of the block; depends on nothing.
`default_nettype none

package qpr_pkg;

  // Field widths
  localparam int CoordW = 16;  // Q8.8 coordinate, Q2.14 quaternion part
  localparam int ShiftW = 17;  // point minus center

  // Register indexes on the configuration port
  typedef enum logic [2:0] {
    CFG_QUAT_W   = 3'd0,
    CFG_QUAT_X   = 3'd1,
    CFG_QUAT_Y   = 3'd2,
    CFG_QUAT_Z   = 3'd3,
    CFG_CENTER_X = 3'd4,
    CFG_CENTER_Y = 3'd5,
    CFG_CENTER_Z = 3'd6
  } cfg_idx_e;

  // Reset values: identity rotation about (4.0, 4.0, 4.0)
  localparam logic signed [CoordW-1:0] QuatWReset   = 16'sd16384;
  localparam logic signed [CoordW-1:0] QuatVReset   = 16'sd0;
  localparam logic signed [CoordW-1:0] CenterReset  = 16'sd1024;

  // Input beat
  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
  } point_t;

  // Output beat
  typedef struct packed {
    logic signed [CoordW-1:0] rotated_x;
    logic signed [CoordW-1:0] rotated_y;
    logic signed [CoordW-1:0] rotated_z;
    logic                     clipped;
  } rotated_t;

  typedef struct packed {
    logic signed [CoordW-1:0] w;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } quat_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } center_t;

  // Point relative to the center
  typedef struct packed {
    logic signed [ShiftW-1:0] x;
    logic signed [ShiftW-1:0] y;
    logic signed [ShiftW-1:0] z;
  } shift_t;

  // Entry of the queue between front and back
  typedef struct packed {
    point_t point;
    shift_t shift;
  } qpr_item_t;

endpackage

`default_nettype wire

>>> rtl/qpr_front.sv
// Front end: takes input beats, subtracts the center, hands entries to the queue.
// Depends on qpr_pkg.
`default_nettype none

module qpr_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  qpr_pkg::point_t    in_item_i,
  input  qpr_pkg::center_t   center_i,
  output logic               q_valid_o,
  input  logic               q_stall_i,
  output qpr_pkg::qpr_item_t q_item_o
);
  import qpr_pkg::*;

  logic      valid_q, valid_d;
  qpr_item_t item_q;
  logic      load;

  // Stall only while holding an entry the queue refuses
  assign in_stall_o = valid_q && q_stall_i;
  assign load       = in_valid_i && !in_stall_o;

  // Advance the holding register
  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (!q_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Shift the point by the center
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.point   <= in_item_i;
      item_q.shift.x <= ShiftW'(in_item_i.point_x) - ShiftW'(center_i.x);
      item_q.shift.y <= ShiftW'(in_item_i.point_y) - ShiftW'(center_i.y);
      item_q.shift.z <= ShiftW'(in_item_i.point_z) - ShiftW'(center_i.z);
    end
  end

  assign q_valid_o = valid_q;
  assign q_item_o  = item_q;

endmodule

`default_nettype wire

>>> rtl/qpr_queue.sv
// Short queue between the front end and the arithmetic back end.
// Depends on qpr_pkg.
`default_nettype none

module qpr_queue #(
  parameter int Depth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_stall_o,
  input  qpr_pkg::qpr_item_t push_item_i,
  output logic               pop_valid_o,
  input  logic               pop_stall_i,
  output qpr_pkg::qpr_item_t pop_item_o
);
  import qpr_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  qpr_item_t           mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                push, pop;

  assign push_stall_o = (cnt_q == CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && !push_stall_o;
  assign pop          = pop_valid_o && !pop_stall_i;
  assign pop_item_o   = mem_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Write the entry
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/qpr_back.sv
// Back end: three-stage pipeline for t = v x s, u = v x t, and the final sum.
// Depends on qpr_pkg.
`default_nettype none

module qpr_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pop_valid_i,
  output logic               pop_stall_o,
  input  qpr_pkg::qpr_item_t pop_item_i,
  input  qpr_pkg::quat_t     quat_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output qpr_pkg::rotated_t  out_item_o
);
  import qpr_pkg::*;

  localparam int TW   = 20;  // t = floor(v x s / 2^14)
  localparam int UW   = 23;  // u and a
  localparam int SumW = 26;
  localparam logic signed [SumW-1:0] RMax = 26'sd32767;
  localparam logic signed [SumW-1:0] RMin = -26'sd32768;

  // floor((qa*sb - qc*sd) / 2^14) for the first cross product
  function automatic logic signed [TW-1:0] cross_s(
    input logic signed [CoordW-1:0] qa, input logic signed [ShiftW-1:0] sb,
    input logic signed [CoordW-1:0] qc, input logic signed [ShiftW-1:0] sd);
    logic signed [33:0] diff;
    diff = 34'(qa) * 34'(sb) - 34'(qc) * 34'(sd);
    return diff[33:14];
  endfunction

  // floor((qa*tb - qc*td) / 2^14) for the second cross product
  function automatic logic signed [UW-1:0] cross_t(
    input logic signed [CoordW-1:0] qa, input logic signed [TW-1:0] tb,
    input logic signed [CoordW-1:0] qc, input logic signed [TW-1:0] td);
    logic signed [36:0] diff;
    diff = 37'(qa) * 37'(tb) - 37'(qc) * 37'(td);
    return diff[36:14];
  endfunction

  // floor(2*w*t / 2^14)
  function automatic logic signed [UW-1:0] scale_w(
    input logic signed [CoordW-1:0] w, input logic signed [TW-1:0] t);
    logic signed [35:0] prod;
    prod = 36'(w) * 36'(t);
    return prod[35:13];
  endfunction

  // Sum and saturate one coordinate; bit 16 flags clipping
  function automatic logic [CoordW:0] finish(
    input logic signed [CoordW-1:0] p, input logic signed [UW-1:0] a,
    input logic signed [UW-1:0] u);
    logic signed [SumW-1:0] r;
    r = SumW'(p) + SumW'(a) + SumW'($signed({u, 1'b0}));
    if (r > RMax) begin
      return {1'b1, RMax[CoordW-1:0]};
    end else if (r < RMin) begin
      return {1'b1, RMin[CoordW-1:0]};
    end
    return {1'b0, r[CoordW-1:0]};
  endfunction

  logic                   s1_v_q, s1_v_d, s2_v_q, s2_v_d, s3_v_q, s3_v_d;
  logic                   s1_rdy, s2_rdy, s3_rdy;
  point_t                 s1_p_q, s2_p_q;
  logic signed [TW-1:0]   tx_q, ty_q, tz_q;
  logic signed [UW-1:0]   ux_q, uy_q, uz_q, ax_q, ay_q, az_q;
  logic [CoordW:0]        fx, fy, fz;
  rotated_t               out_q;

  // Each stage advances when empty or when the next one moves
  assign s3_rdy      = !s3_v_q || !out_stall_i;
  assign s2_rdy      = !s2_v_q || s3_rdy;
  assign s1_rdy      = !s1_v_q || s2_rdy;
  assign pop_stall_o = !s1_rdy;

  always_comb begin
    s1_v_d = s1_rdy ? pop_valid_i : s1_v_q;
    s2_v_d = s2_rdy ? s1_v_q      : s2_v_q;
    s3_v_d = s3_rdy ? s2_v_q      : s3_v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
      s2_v_q <= s2_v_d;
      s3_v_q <= s3_v_d;
    end
  end

  // Stage 1: t = v x s
  always_ff @(posedge clk_i) begin
    if (pop_valid_i && s1_rdy) begin
      s1_p_q <= pop_item_i.point;
      tx_q   <= cross_s(quat_i.y, pop_item_i.shift.z, quat_i.z, pop_item_i.shift.y);
      ty_q   <= cross_s(quat_i.z, pop_item_i.shift.x, quat_i.x, pop_item_i.shift.z);
      tz_q   <= cross_s(quat_i.x, pop_item_i.shift.y, quat_i.y, pop_item_i.shift.x);
    end
  end

  // Stage 2: u = v x t and a = 2*w*t
  always_ff @(posedge clk_i) begin
    if (s1_v_q && s2_rdy) begin
      s2_p_q <= s1_p_q;
      ux_q   <= cross_t(quat_i.y, tz_q, quat_i.z, ty_q);
      uy_q   <= cross_t(quat_i.z, tx_q, quat_i.x, tz_q);
      uz_q   <= cross_t(quat_i.x, ty_q, quat_i.y, tx_q);
      ax_q   <= scale_w(quat_i.w, tx_q);
      ay_q   <= scale_w(quat_i.w, ty_q);
      az_q   <= scale_w(quat_i.w, tz_q);
    end
  end

  // Stage 3: point + a + 2u, saturated (s + center is the point itself)
  assign fx = finish(s2_p_q.point_x, ax_q, ux_q);
  assign fy = finish(s2_p_q.point_y, ay_q, uy_q);
  assign fz = finish(s2_p_q.point_z, az_q, uz_q);

  always_ff @(posedge clk_i) begin
    if (s2_v_q && s3_rdy) begin
      out_q.rotated_x <= fx[CoordW-1:0];
      out_q.rotated_y <= fy[CoordW-1:0];
      out_q.rotated_z <= fz[CoordW-1:0];
      out_q.clipped   <= fx[CoordW] | fy[CoordW] | fz[CoordW];
    end
  end

  assign out_valid_o = s3_v_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

>>> rtl/quaternion_point_rotate.sv
// Top level of the quaternion point rotator: configuration registers, front, queue, back.
// Depends on qpr_pkg, qpr_front, qpr_queue, qpr_back.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+------------------------------------
//   in       | in_valid_i/in_stall_o | in_item_i  (point_x/y/z, Q8.8)
//   out      | out_valid_o/out_stall_i | out_item_o (rotated_x/y/z, clipped)
//   config   | cfg_we_i              | cfg_idx_i, cfg_wdata_i
//
// One point per cycle sustained while the output is not stalled; an accepted point
// loads the front register, then passes the queue write, t = v x s, u = v x t with
// 2wt, and the sum register before it shows on the output.
// Reset empties the pipeline and loads an identity rotation about (4, 4, 4).
// An output stall fills the back stages, then the queue, then the front.
`default_nettype none

module quaternion_point_rotate #(
  parameter int QueueDepth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  qpr_pkg::point_t   in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output qpr_pkg::rotated_t out_item_o,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [15:0]       cfg_wdata_i
);
  import qpr_pkg::*;

  quat_t     quat_q;
  center_t   center_q;
  logic      fq_valid, fq_stall, qb_valid, qb_stall;
  qpr_item_t fq_item, qb_item;

  // Write configuration registers; unknown indexes drop the write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quat_q.w   <= QuatWReset;
      quat_q.x   <= QuatVReset;
      quat_q.y   <= QuatVReset;
      quat_q.z   <= QuatVReset;
      center_q.x <= CenterReset;
      center_q.y <= CenterReset;
      center_q.z <= CenterReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_QUAT_W:   quat_q.w   <= cfg_wdata_i;
        CFG_QUAT_X:   quat_q.x   <= cfg_wdata_i;
        CFG_QUAT_Y:   quat_q.y   <= cfg_wdata_i;
        CFG_QUAT_Z:   quat_q.z   <= cfg_wdata_i;
        CFG_CENTER_X: center_q.x <= cfg_wdata_i;
        CFG_CENTER_Y: center_q.y <= cfg_wdata_i;
        CFG_CENTER_Z: center_q.z <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  qpr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .center_i   (center_q),
    .q_valid_o  (fq_valid),
    .q_stall_i  (fq_stall),
    .q_item_o   (fq_item)
  );

  qpr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_stall_o (fq_stall),
    .push_item_i  (fq_item),
    .pop_valid_o  (qb_valid),
    .pop_stall_i  (qb_stall),
    .pop_item_o   (qb_item)
  );

  qpr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (qb_valid),
    .pop_stall_o (qb_stall),
    .pop_item_i  (qb_item),
    .quat_i      (quat_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

>>> rtl/qpr_checker.sv
// Port-level checks for the quaternion point rotator, bound to the top level.
// Depends on qpr_pkg and quaternion_point_rotate.
`default_nettype none

module qpr_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input qpr_pkg::rotated_t out_item_o
);
  import qpr_pkg::*;

  localparam logic signed [CoordW-1:0] Top = 16'sd32767;
  localparam logic signed [CoordW-1:0] Bot = -16'sd32768;

  logic at_rail;

  assign at_rail = (out_item_o.rotated_x == Top) || (out_item_o.rotated_x == Bot) ||
                   (out_item_o.rotated_y == Top) || (out_item_o.rotated_y == Bot) ||
                   (out_item_o.rotated_z == Top) || (out_item_o.rotated_z == Bot);

  // A stalled output beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled output beat changed");

  // The clip flag only comes with a saturated coordinate
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.clipped |-> at_rail)
    else $error("clipped set without a saturated coordinate");

  // A coordinate strictly inside the range everywhere means no clip
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !at_rail |-> !out_item_o.clipped)
    else $error("clipped set on an unsaturated beat");

  // The input side backs up only after the output side held a beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without an output stall");

endmodule

bind quaternion_point_rotate qpr_checker u_qpr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for quaternion_point_rotate: drives points with random gaps,
// stalls results at random and checks every beat against a fixed-point predictor.
// Depends on qpr_pkg and the RTL of quaternion_point_rotate.

module testbench;
  import qpr_pkg::*;

  localparam logic [2:0] CFG_UNUSED  = 3'd7;  // no register here, write is dropped
  localparam int         CycleLimit  = 400000;
  localparam int         ItemsPerSet = 150;
  localparam int         NumSets     = 12;

  // Expected rotated points, computed from the register copy at input accept
  class rotate_scoreboard;
    quat_t    quat;
    center_t  center;
    rotated_t rotations_due[$];
    int       mismatches;

    function new();
      quat       = '{w: QuatWReset, x: QuatVReset, y: QuatVReset, z: QuatVReset};
      center     = '{x: CenterReset, y: CenterReset, z: CenterReset};
      mismatches = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        CFG_QUAT_W:   quat.w   = val;
        CFG_QUAT_X:   quat.x   = val;
        CFG_QUAT_Y:   quat.y   = val;
        CFG_QUAT_Z:   quat.z   = val;
        CFG_CENTER_X: center.x = val;
        CFG_CENTER_Y: center.y = val;
        CFG_CENTER_Z: center.z = val;
        default: ;
      endcase
    endfunction

    // s = p - c, t = v x s, u = v x t, r = s + 2wt + 2u + c, all floored by 2^14
    function rotated_t rotate_point(point_t p);
      longint   w, qx, qy, qz, cx, cy, cz, sx, sy, sz, tx, ty, tz, ux, uy, uz;
      longint   r[3];
      rotated_t res;
      w  = longint'($signed(quat.w));
      qx = longint'($signed(quat.x));
      qy = longint'($signed(quat.y));
      qz = longint'($signed(quat.z));
      cx = longint'($signed(center.x));
      cy = longint'($signed(center.y));
      cz = longint'($signed(center.z));
      sx = longint'($signed(p.point_x)) - cx;
      sy = longint'($signed(p.point_y)) - cy;
      sz = longint'($signed(p.point_z)) - cz;
      tx = (qy * sz - qz * sy) >>> 14;
      ty = (qz * sx - qx * sz) >>> 14;
      tz = (qx * sy - qy * sx) >>> 14;
      ux = (qy * tz - qz * ty) >>> 14;
      uy = (qz * tx - qx * tz) >>> 14;
      uz = (qx * ty - qy * tx) >>> 14;
      r[0] = sx + ((2 * w * tx) >>> 14) + 2 * ux + cx;
      r[1] = sy + ((2 * w * ty) >>> 14) + 2 * uy + cy;
      r[2] = sz + ((2 * w * tz) >>> 14) + 2 * uz + cz;
      // Saturate to Q8.8 and flag it
      res.clipped = 1'b0;
      for (int i = 0; i < 3; i++) begin
        if (r[i] > 32767) begin
          r[i] = 32767;
          res.clipped = 1'b1;
        end else if (r[i] < -32768) begin
          r[i] = -32768;
          res.clipped = 1'b1;
        end
      end
      res.rotated_x = r[0][15:0];
      res.rotated_y = r[1][15:0];
      res.rotated_z = r[2][15:0];
      return res;
    endfunction

    function void note_point(point_t p);
      rotations_due.push_back(rotate_point(p));
    endfunction

    function void report(string field, logic signed [15:0] want, logic signed [15:0] got);
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
    endfunction

    function void check_rotated(rotated_t got);
      rotated_t want;
      if (rotations_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected beat expected none actual %h", $time, got);
        return;
      end
      want = rotations_due.pop_front();
      if (got.rotated_x !== want.rotated_x) report("rotated_x", want.rotated_x, got.rotated_x);
      if (got.rotated_y !== want.rotated_y) report("rotated_y", want.rotated_y, got.rotated_y);
      if (got.rotated_z !== want.rotated_z) report("rotated_z", want.rotated_z, got.rotated_z);
      if (got.clipped !== want.clipped)
        report("clipped", {15'b0, want.clipped}, {15'b0, got.clipped});
    endfunction

    function void flag_leftover();
      if (rotations_due.size() != 0) begin
        mismatches++;
        $display("%0t: missing beats expected %0d actual 0", $time, rotations_due.size());
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  point_t      in_item;
  logic        out_valid;
  logic        out_stall;
  rotated_t    out_item;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [15:0] cfg_wdata;

  bit               src_idle;
  bit               sink_idle;
  int               cycle_count = 0;
  rotate_scoreboard sb;

  quaternion_point_rotate u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Watch both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_point(in_item);
      if (out_valid && !out_stall) sb.check_rotated(out_item);
    end
  end

  // Result side: when sink idling is on, stall at random, then take one beat
  initial begin : result_sink
    int hold;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      hold = sink_idle ? $urandom_range(0, 9) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Offer one point, after a random gap when source idling is on; return at the falling edge after accept
  task automatic send_point(point_t p);
    int gap;
    gap = src_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= p;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_xyz(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    send_point('{point_x: x, point_y: y, point_z: z});
  endtask

  // Hold input low until every expected beat has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.rotations_due.size() != 0) @(negedge clk);
  endtask

  // Write one register; the enable stays high for back-to-back writes
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
  endtask

  // Drain, then load all seven registers, optionally poking the unused index
  task automatic apply_config(quat_t q, center_t c, bit poke_unused);
    drain();
    write_reg(CFG_QUAT_W, q.w);
    write_reg(CFG_QUAT_X, q.x);
    write_reg(CFG_QUAT_Y, q.y);
    write_reg(CFG_QUAT_Z, q.z);
    write_reg(CFG_CENTER_X, c.x);
    write_reg(CFG_CENTER_Y, c.y);
    write_reg(CFG_CENTER_Z, c.z);
    if (poke_unused) write_reg(CFG_UNUSED, 16'($urandom));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_extreme();
    case ($urandom_range(0, 3))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      default: return 16'h4000;
    endcase
  endfunction

  // Kind 0: extremes, 1: full range, else within +/-1.0
  function automatic logic [15:0] quat_part(int kind);
    if (kind == 0) return pick_extreme();
    if (kind == 1) return 16'($urandom);
    return 16'($urandom_range(0, 32768) - 16384);
  endfunction

  function automatic logic [15:0] center_part(int kind);
    if (kind == 0) return pick_extreme();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 4095) - 2048);
  endfunction

  // Mostly points near the center so results stay in range, some full range
  function automatic point_t random_point(center_t c);
    point_t p;
    if ($urandom_range(0, 3) == 0) begin
      p.point_x = 16'($urandom);
      p.point_y = 16'($urandom);
      p.point_z = 16'($urandom);
    end else begin
      p.point_x = 16'(c.x + $urandom_range(0, 8191) - 4096);
      p.point_y = 16'(c.y + $urandom_range(0, 8191) - 4096);
      p.point_z = 16'(c.z + $urandom_range(0, 8191) - 4096);
    end
    return p;
  endfunction

  initial begin : stimulus
    quat_t   q;
    center_t c;
    int      kind;
    in_valid  = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    sb        = new();
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Reset registers: identity rotation about (4, 4, 4)
    send_xyz(16'h0000, 16'h0000, 16'h0000);
    send_xyz(16'h0400, 16'h0400, 16'h0400);
    send_xyz(16'h7fff, 16'h7fff, 16'h7fff);
    send_xyz(16'h8000, 16'h8000, 16'h8000);

    // Write to the unused index must leave the registers alone
    drain();
    write_reg(CFG_UNUSED, 16'h5a5a);
    cfg_we <= 1'b0;
    send_xyz(16'h0100, 16'hff00, 16'h0200);

    // Quarter turn about z around the origin
    apply_config('{w: 16'sd11585, x: 16'sd0, y: 16'sd0, z: 16'sd11585},
                 '{x: 16'sd0, y: 16'sd0, z: 16'sd0}, 1'b0);
    send_xyz(16'h0100, 16'h0000, 16'h0000);
    send_xyz(16'h0000, 16'h0100, 16'h0000);
    send_xyz(16'h1234, 16'hedcb, 16'h0777);

    // Half turn about x: negating the minimum overflows and saturates high
    apply_config('{w: 16'sd0, x: 16'sd16384, y: 16'sd0, z: 16'sd0},
                 '{x: 16'sd0, y: 16'sd0, z: 16'sd0}, 1'b0);
    send_xyz(16'h7fff, 16'h8000, 16'h8000);
    send_xyz(16'h8000, 16'h7fff, 16'h7fff);
    send_xyz(16'h0001, 16'hffff, 16'h0001);

    // Non-unit quaternion at the negative extreme, center at the positive one
    apply_config('{w: 16'h8000, x: 16'h8000, y: 16'h8000, z: 16'h8000},
                 '{x: 16'h7fff, y: 16'h7fff, z: 16'h7fff}, 1'b0);
    send_xyz(16'h8000, 16'h8000, 16'h8000);
    send_xyz(16'h7fff, 16'h8000, 16'h0000);
    send_xyz(16'h7fff, 16'h7fff, 16'h7fff);

    // Positive extreme quaternion, center at the negative extreme
    apply_config('{w: 16'h7fff, x: 16'h7fff, y: 16'h7fff, z: 16'h7fff},
                 '{x: 16'h8000, y: 16'h8000, z: 16'h8000}, 1'b0);
    send_xyz(16'h7fff, 16'h7fff, 16'h7fff);
    send_xyz(16'h8000, 16'h7fff, 16'h8000);
    send_xyz(16'h8000, 16'h8000, 16'h8000);
    send_xyz(16'h0000, 16'h5555, 16'haaaa);

    // Random sets: new registers each time, idling mixed per set
    for (int set = 0; set < NumSets; set++) begin
      kind = (set < 2) ? set : $urandom_range(0, 5);
      q.w = quat_part(kind);
      q.x = quat_part(kind);
      q.y = quat_part(kind);
      q.z = quat_part(kind);
      c.x = center_part(kind);
      c.y = center_part(kind);
      c.z = center_part(kind);
      apply_config(q, c, set[0]);
      src_idle  = set[0];
      sink_idle = set[1];
      for (int n = 0; n < ItemsPerSet; n++) send_point(random_point(c));
    end

    // Let the pipeline empty, then look for stray beats
    drain();
    repeat (8) @(negedge clk);
    sb.flag_leftover();
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
